>>> rtl/core/first_fit_arena_allocator_assert.svh
// assertion macros for the arena allocator
`ifndef FIRST_FIT_ARENA_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define FFA_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arena allocator check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arena allocator check failed");

`endif

>>> rtl/core/ffa_pkg.sv
package ffa_pkg;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REINIT = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_ZERO_SIZE    = 3'd1,
      ST_NO_SPACE     = 3'd2,
      ST_BAD_POINTER  = 3'd3,
      ST_ALREADY_FREE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_RD,
      S_EV,
      S_SHR,
      S_SHW,
      S_SP1,
      S_SP2,
      S_MRD,
      S_MA,
      S_MB,
      S_RMR,
      S_RMW
   } state_type;

   localparam int STATUS_W = 3;
   localparam int OFFSET_W = 12;
   localparam int USED_W   = 13;

endpackage

>>> rtl/core/ffa_ram.sv
module ffa_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/first_fit_arena_allocator.sv
// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+------------------------
// request   | req_command, req_request_size, req_block_offset   | start high, busy low
// response  | rsp_status, rsp_result_offset, rsp_granted_size,  | rsp_strobe, one cycle
//           | rsp_bytes_in_use                                  |
//
// one sequencer walks the block table, which lives in a single ram with a
// registered read port; every table visit is a read followed by a use of the data
// allocate scans the blocks, shifts entries up by one for a split, and on a
// miss runs a merge pass over neighbor pairs that moves entries down, then scans again
// free scans the blocks; reinit and reset each take one table write
// after reset busy is high for one cycle while the first block entry is written
// the receiver cannot stall: each response shows for exactly one cycle
module first_fit_arena_allocator
   import ffa_pkg::*;
#(
   parameter int ARENA_BYTES  = 4096,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_BLOCKS   = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [15:0]         req_request_size,
   input  logic [15:0]         req_block_offset,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OFFSET_W-1:0] rsp_result_offset,
   output logic [OFFSET_W-1:0] rsp_granted_size,
   output logic [USED_W-1:0]   rsp_bytes_in_use
);

   // widths of payload sizes, table indexes and wide sums
   localparam int SIZE_W  = $clog2(ARENA_BYTES + 1);
   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int WIDE_W  = ((SIZE_W > 16) ? SIZE_W : 16) + 2;
   localparam int ENTRY_W = SIZE_W + 1;
   // reciprocal of the alignment, exact for every rounded request size
   localparam int RECIP_SH = 24;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int PROD_W   = WIDE_W + RECIP_W;

   localparam logic [WIDE_W-1:0] HDR_WD    = WIDE_W'(HEADER_BYTES);
   localparam logic [WIDE_W-1:0] ARENA_WD  = WIDE_W'(ARENA_BYTES);
   localparam logic [WIDE_W-1:0] ALIGN_WD  = WIDE_W'(ALIGN_BYTES);
   localparam logic [WIDE_W-1:0] ROUND_WD  = WIDE_W'(ALIGN_BYTES - 1);
   localparam logic [RECIP_W-1:0] RECIP_WD =
      RECIP_W'(((1 << RECIP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES);
   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [WIDE_W-1:0]     need_ff, need_in;
   logic [15:0]           ptr_ff, ptr_in;
   logic                  pass_ff, pass_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [WIDE_W-1:0]     start_ff, start_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SIZE_W-1:0]     used_ff, used_in;
   logic [ENTRY_W-1:0]    a_ff, a_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic                  init_rsp_ff, init_rsp_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [OFFSET_W-1:0]   rsp_size_ff, rsp_size_in;

   // table port
   logic                  wr_en;
   logic [CNT_W-1:0]      wr_idx, rd_idx;
   logic [ENTRY_W-1:0]    wr_data, rd_data;

   logic                  rd_free;
   logic [WIDE_W-1:0]     rd_size_w, a_size_w, used_w, req_w, ptr_w;
   logic [WIDE_W-1:0]     entry_end, sum_w;
   logic [WIDE_W-1:0]     round_w;
   logic [PROD_W-1:0]     quot_prod;

   ffa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[IDX_W-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_idx[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   assign rd_free   = rd_data[SIZE_W];
   assign rd_size_w = WIDE_W'(rd_data[SIZE_W-1:0]);
   assign a_size_w  = WIDE_W'(a_ff[SIZE_W-1:0]);
   assign used_w    = WIDE_W'(used_ff);
   assign req_w     = WIDE_W'(req_request_size);
   assign ptr_w     = WIDE_W'(ptr_ff);
   // start of the next block once the one just read is passed
   assign entry_end = start_ff + HDR_WD + rd_size_w;
   // merged payload of two neighbors
   assign sum_w     = a_size_w + HDR_WD + rd_size_w;
   // round up to the alignment: quotient by reciprocal multiply
   assign round_w   = req_w + ROUND_WD;
   assign quot_prod = round_w * RECIP_WD;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_rsp_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= ONE_CNT;
         used_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         init_rsp_ff   <= init_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      need_ff       <= need_in;
      ptr_ff        <= ptr_in;
      pass_ff       <= pass_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      start_ff      <= start_in;
      a_ff          <= a_in;
      rem_ff        <= rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_size_ff   <= rsp_size_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      need_in       = need_ff;
      ptr_in        = ptr_ff;
      pass_in       = pass_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      a_in          = a_ff;
      rem_in        = rem_ff;
      init_rsp_in   = init_rsp_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_size_in   = rsp_size_ff;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_data       = '0;
      rd_idx        = idx_ff;

      case (state_ff)
         // one free block spanning the arena
         S_INIT: begin
            wr_en       = 1'b1;
            wr_idx      = '0;
            wr_data     = {1'b1, INIT_SIZE};
            count_in    = ONE_CNT;
            used_in     = '0;
            init_rsp_in = 1'b0;
            if (init_rsp_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_offset_in = '0;
               rsp_size_in   = '0;
            end
            state_in = S_IDLE;
         end

         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_command);
               ptr_in   = req_block_offset;
               need_in  = WIDE_W'(quot_prod[PROD_W-1:RECIP_SH] * ALIGN_WD);
               pass_in  = 1'b0;
               idx_in   = '0;
               start_in = '0;
               case (cmd_type'(req_command))
                  CMD_ALLOC: begin
                     if (req_request_size == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_ZERO_SIZE;
                        rsp_offset_in = '0;
                        rsp_size_in   = '0;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  CMD_FREE: begin
                     if (WIDE_W'(req_block_offset) >= ARENA_WD) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_BAD_POINTER;
                        rsp_offset_in = '0;
                        rsp_size_in   = '0;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  CMD_REINIT: begin
                     init_rsp_in = 1'b1;
                     state_in    = S_INIT;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_BAD_POINTER;
                     rsp_offset_in = '0;
                     rsp_size_in   = '0;
                  end
               endcase
            end
         end

         // issue a read of the block under the scan pointer
         S_RD: begin
            rd_idx = idx_ff;
            if (idx_ff >= count_ff) begin
               if (cmd_ff == CMD_ALLOC && !pass_ff) begin
                  idx_in   = '0;
                  state_in = S_MRD;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = (cmd_ff == CMD_ALLOC) ? ST_NO_SPACE : ST_BAD_POINTER;
                  rsp_offset_in = '0;
                  rsp_size_in   = '0;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_EV;
            end
         end

         // judge the block that came back
         S_EV: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (rd_free && rd_size_w >= need_ff) begin
                  if (rd_size_w >= need_ff + HDR_WD && count_ff < MAX_CNT) begin
                     rem_in   = SIZE_W'(rd_size_w - need_ff - HDR_WD);
                     k_in     = count_ff;
                     state_in = S_SHR;
                  end else begin
                     // grant the whole block
                     wr_en         = 1'b1;
                     wr_idx        = idx_ff;
                     wr_data       = {1'b0, rd_data[SIZE_W-1:0]};
                     used_in       = SIZE_W'(used_w + rd_size_w + HDR_WD);
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_offset_in = OFFSET_W'(start_ff + HDR_WD);
                     rsp_size_in   = OFFSET_W'(rd_size_w);
                     state_in      = S_IDLE;
                  end
               end else begin
                  start_in = entry_end;
                  idx_in   = idx_ff + ONE_CNT;
                  state_in = S_RD;
               end
            end else begin
               if (start_ff + HDR_WD == ptr_w) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  if (rd_free) begin
                     rsp_status_in = ST_ALREADY_FREE;
                     rsp_offset_in = '0;
                     rsp_size_in   = '0;
                  end else begin
                     wr_en         = 1'b1;
                     wr_idx        = idx_ff;
                     wr_data       = {1'b1, rd_data[SIZE_W-1:0]};
                     used_in       = SIZE_W'(used_w - rd_size_w - HDR_WD);
                     rsp_status_in = ST_OK;
                     rsp_offset_in = OFFSET_W'(ptr_w);
                     rsp_size_in   = OFFSET_W'(rd_size_w);
                  end
               end else begin
                  start_in = entry_end;
                  idx_in   = idx_ff + ONE_CNT;
                  state_in = S_RD;
               end
            end
         end

         // open a hole after the split block, moving entries up by one
         S_SHR: begin
            rd_idx = k_ff - ONE_CNT;
            if (k_ff > idx_ff + ONE_CNT) begin
               state_in = S_SHW;
            end else begin
               state_in = S_SP1;
            end
         end

         S_SHW: begin
            wr_en    = 1'b1;
            wr_idx   = k_ff;
            wr_data  = rd_data;
            k_in     = k_ff - ONE_CNT;
            state_in = S_SHR;
         end

         S_SP1: begin
            wr_en    = 1'b1;
            wr_idx   = idx_ff + ONE_CNT;
            wr_data  = {1'b1, rem_ff};
            state_in = S_SP2;
         end

         S_SP2: begin
            wr_en         = 1'b1;
            wr_idx        = idx_ff;
            wr_data       = {1'b0, SIZE_W'(need_ff)};
            count_in      = count_ff + ONE_CNT;
            used_in       = SIZE_W'(used_w + need_ff + HDR_WD);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
            rsp_offset_in = OFFSET_W'(start_ff + HDR_WD);
            rsp_size_in   = OFFSET_W'(need_ff);
            state_in      = S_IDLE;
         end

         // merge pass: look at the pair at idx and idx + 1
         S_MRD: begin
            rd_idx = idx_ff;
            if (idx_ff + ONE_CNT >= count_ff) begin
               pass_in  = 1'b1;
               idx_in   = '0;
               start_in = '0;
               state_in = S_RD;
            end else begin
               state_in = S_MA;
            end
         end

         S_MA: begin
            a_in     = rd_data;
            rd_idx   = idx_ff + ONE_CNT;
            state_in = S_MB;
         end

         S_MB: begin
            if (a_ff[SIZE_W] && rd_free) begin
               wr_en    = 1'b1;
               wr_idx   = idx_ff;
               wr_data  = {1'b1, SIZE_W'(sum_w)};
               k_in     = idx_ff + ONE_CNT;
               state_in = S_RMR;
            end else begin
               idx_in   = idx_ff + ONE_CNT;
               state_in = S_MRD;
            end
         end

         // close the gap left by the absorbed block
         S_RMR: begin
            rd_idx = k_ff + ONE_CNT;
            if (k_ff + ONE_CNT < count_ff) begin
               state_in = S_RMW;
            end else begin
               count_in = count_ff - ONE_CNT;
               state_in = S_MRD;
            end
         end

         S_RMW: begin
            wr_en    = 1'b1;
            wr_idx   = k_ff;
            wr_data  = rd_data;
            k_in     = k_ff + ONE_CNT;
            state_in = S_RMR;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_offset = rsp_offset_ff;
   assign rsp_granted_size  = rsp_size_ff;
   assign rsp_bytes_in_use  = used_w[USED_W-1:0];

`include "first_fit_arena_allocator_assert.svh"

   // the table never empties and never overflows
   `FFA_ASSERT_IMPLY(a_count_range, 1'b1, (count_ff != '0) && (count_ff <= MAX_CNT))
   // bytes in use never exceed the arena
   `FFA_ASSERT_IMPLY(a_used_bound, 1'b1, used_w <= ARENA_WD)
   // a failed request carries no offset
   `FFA_ASSERT_IMPLY(a_fail_offset, rsp_strobe_ff && (rsp_status_ff != ST_OK), rsp_offset_ff == '0)
   // an accepted request either starts work or answers at once
   `FFA_ASSERT_NEXT(a_accept_moves, start && !busy, busy || rsp_strobe_ff)

endmodule

>>> verif/first_fit_arena_allocator_test.sv
module first_fit_arena_allocator_test
   import ffa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // block geometry, kept equal to the instance below
   localparam int ARENA_BYTES  = 4096;
   localparam int ALIGN_BYTES  = 8;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 256;

   // generous: a worst allocate is a double scan plus a merge with table moves
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int SETTLE_CYCLES = 64;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] size;
      logic [15:0] offset;
      int          idle_pct;   // chance in percent that the sender holds this request back at an edge
      bit          drain;      // hold this request until every response is back
   } arena_request;

   typedef struct {
      status_type  status;
      logic [11:0] offset;
      logic [11:0] size;
      logic [12:0] in_use;
   } arena_response;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = CMD_ALLOC;
   logic [15:0] req_request_size = '0;
   logic [15:0] req_block_offset = '0;
   logic rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [OFFSET_W-1:0] rsp_result_offset;
   logic [OFFSET_W-1:0] rsp_granted_size;
   logic [USED_W-1:0] rsp_bytes_in_use;

   first_fit_arena_allocator #(
      .ARENA_BYTES  (ARENA_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_request_size  (req_request_size),
      .req_block_offset  (req_block_offset),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_result_offset (rsp_result_offset),
      .rsp_granted_size  (rsp_granted_size),
      .rsp_bytes_in_use  (rsp_bytes_in_use)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // shadow of the block table: payload size and free mark per block
   int unsigned arena_sizes[MAX_BLOCKS];
   bit          arena_free[MAX_BLOCKS];
   int unsigned arena_blocks;
   int unsigned arena_used;

   // payload offsets currently handed out, used to aim frees at live blocks
   int unsigned live_offsets[$];

   arena_request  pending_requests[$];
   arena_response awaited_responses[$];
   int            error_count = 0;
   int unsigned   cycle_count = 0;

   function automatic void arena_restore();
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         arena_sizes[k] = 0;
         arena_free[k]  = 1'b0;
      end
      arena_sizes[0] = ARENA_BYTES - HEADER_BYTES;
      arena_free[0]  = 1'b1;
      arena_blocks   = 1;
      arena_used     = 0;
      live_offsets.delete();
   endfunction

   // close the gap left by entry idx
   function automatic void drop_block(int unsigned idx);
      for (int unsigned k = idx; k + 1 < arena_blocks; k++) begin
         arena_sizes[k] = arena_sizes[k + 1];
         arena_free[k]  = arena_free[k + 1];
      end
      arena_blocks--;
   endfunction

   function automatic void coalesce_free_runs();
      int unsigned i;
      i = 0;
      while (i + 1 < arena_blocks) begin
         if (arena_free[i] && arena_free[i + 1]) begin
            arena_sizes[i] += HEADER_BYTES + arena_sizes[i + 1];
            drop_block(i + 1);
         end else begin
            i++;
         end
      end
   endfunction

   function automatic bit grab_first_fit(input int unsigned need,
                                         output int unsigned off,
                                         output int unsigned granted);
      int unsigned base;
      base = 0;
      off = 0;
      granted = 0;
      for (int unsigned i = 0; i < arena_blocks && i < MAX_BLOCKS; i++) begin
         if (arena_free[i] && arena_sizes[i] >= need) begin
            // split only when the tail can carry its own header and the table has room
            if (arena_sizes[i] >= need + HEADER_BYTES && arena_blocks < MAX_BLOCKS) begin
               for (int unsigned k = arena_blocks; k > i + 1; k--) begin
                  arena_sizes[k] = arena_sizes[k - 1];
                  arena_free[k]  = arena_free[k - 1];
               end
               arena_sizes[i + 1] = arena_sizes[i] - need - HEADER_BYTES;
               arena_free[i + 1]  = 1'b1;
               arena_sizes[i]     = need;
               arena_blocks++;
            end
            arena_free[i] = 1'b0;
            arena_used += arena_sizes[i] + HEADER_BYTES;
            off = base + HEADER_BYTES;
            granted = arena_sizes[i];
            return 1'b1;
         end
         base += HEADER_BYTES + arena_sizes[i];
      end
      return 1'b0;
   endfunction

   function automatic arena_response predict_arena(arena_request r);
      arena_response rsp;
      int unsigned   need, off, granted, base, idx;
      bit            found;
      rsp.status = ST_OK;
      off = 0;
      granted = 0;
      case (r.cmd)
         CMD_ALLOC: begin
            if (r.size == 0) begin
               rsp.status = ST_ZERO_SIZE;
            end else begin
               need = ((int'(r.size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
               if (!grab_first_fit(need, off, granted)) begin
                  // the merge stays in place even when the retry misses
                  coalesce_free_runs();
                  if (!grab_first_fit(need, off, granted)) begin
                     rsp.status = ST_NO_SPACE;
                     off = 0;
                     granted = 0;
                  end
               end
               if (rsp.status == ST_OK) live_offsets.push_back(off);
            end
         end
         CMD_FREE: begin
            rsp.status = ST_BAD_POINTER;
            found = 1'b0;
            base = 0;
            idx = 0;
            if (r.offset < ARENA_BYTES) begin
               for (int unsigned i = 0; i < arena_blocks && i < MAX_BLOCKS; i++) begin
                  if (!found && base + HEADER_BYTES == r.offset) begin
                     found = 1'b1;
                     idx = i;
                  end
                  base += HEADER_BYTES + arena_sizes[i];
               end
               if (found) begin
                  if (arena_free[idx]) begin
                     rsp.status = ST_ALREADY_FREE;
                  end else begin
                     arena_free[idx] = 1'b1;
                     arena_used -= arena_sizes[idx] + HEADER_BYTES;
                     rsp.status = ST_OK;
                     off = r.offset;
                     granted = arena_sizes[idx];
                     foreach (live_offsets[q])
                        if (live_offsets[q] == off) begin
                           live_offsets.delete(q);
                           break;
                        end
                  end
               end
            end
         end
         CMD_REINIT: arena_restore();
         default: rsp.status = ST_BAD_POINTER;
      endcase
      rsp.offset = off[11:0];
      rsp.size   = granted[11:0];
      rsp.in_use = arena_used[12:0];
      return rsp;
   endfunction

   // driver: a request is taken at an edge with start high and busy low
   always @(posedge clock) begin
      arena_request nxt;
      logic         present;
      if (reset) begin
         start <= 1'b0;
      end else begin
         present = start;
         if (start && !busy) begin
            awaited_responses.push_back(predict_arena('{cmd_type'(req_command),
               req_request_size, req_block_offset, 0, 1'b0}));
            present = 1'b0;
         end
         if (!present && pending_requests.size() > 0) begin
            // drain point: sender holds until the block has answered everything
            if (!(pending_requests[0].drain && awaited_responses.size() != 0) &&
                $urandom_range(99) >= pending_requests[0].idle_pct) begin
               nxt = pending_requests.pop_front();
               req_command      <= nxt.cmd;
               req_request_size <= nxt.size;
               req_block_offset <= nxt.offset;
               present = 1'b1;
            end
         end
         start <= present;
      end
   end

   // monitor: every strobe must match the oldest prediction
   always @(posedge clock) begin
      arena_response want;
      if (!reset && rsp_strobe) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none awaited: status %0d offset %0d size %0d used %0d",
                     $time, rsp_status, rsp_result_offset, rsp_granted_size,
                     rsp_bytes_in_use);
            error_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_result_offset !== want.offset) begin
               $display("%0t: result_offset expected %0d actual %0d",
                        $time, want.offset, rsp_result_offset);
               error_count++;
            end
            if (rsp_granted_size !== want.size) begin
               $display("%0t: granted_size expected %0d actual %0d",
                        $time, want.size, rsp_granted_size);
               error_count++;
            end
            if (rsp_bytes_in_use !== want.in_use) begin
               $display("%0t: bytes_in_use expected %0d actual %0d",
                        $time, want.in_use, rsp_bytes_in_use);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic add_request(cmd_type c, int unsigned sz, int unsigned off,
                              int idle, bit drain = 1'b0);
      arena_request r;
      r.cmd      = c;
      r.size     = sz[15:0];
      r.offset   = off[15:0];
      r.idle_pct = idle;
      r.drain    = drain;
      pending_requests.push_back(r);
   endtask

   // mostly small allocations and frees of live blocks, some noise
   task automatic add_random_request(int idle, bit drain);
      int unsigned pick, sz, off;
      pick = $urandom_range(99);
      sz  = $urandom;
      off = $urandom;
      if (pick < 48) begin
         case ($urandom_range(9))
            0:       sz = sz & 16'hffff;
            1:       sz = $urandom_range(4096, 1024);
            2:       sz = 0;
            default: sz = $urandom_range(200, 1);
         endcase
         add_request(CMD_ALLOC, sz, off, idle, drain);
      end else if (pick < 94) begin
         if (live_offsets.size() > 0 && $urandom_range(9) < 8)
            off = live_offsets[$urandom_range(live_offsets.size() - 1)];
         else if ($urandom_range(1))
            off = $urandom_range(ARENA_BYTES - 1);
         add_request(CMD_FREE, sz, off, idle, drain);
      end else if (pick < 97) begin
         add_request(CMD_REINIT, sz, off, idle, drain);
      end else begin
         add_request(CMD_UNUSED, sz, off, idle, drain);
      end
   endtask

   initial begin
      int phase_idle[4];
      arena_restore();
      phase_idle = '{0, 87, 0, 12};

      // directed: zero size, rounding, too large, bad and double frees,
      // merge on miss, exact fit, zero-payload tail, unknown command
      add_request(CMD_ALLOC,  0,      0,      0);
      add_request(CMD_ALLOC,  1,      0,      0);
      add_request(CMD_ALLOC,  4096,   0,      0);
      add_request(CMD_ALLOC,  65535,  0,      0);
      add_request(CMD_FREE,   0,      16,     0);
      add_request(CMD_FREE,   0,      16,     0);
      add_request(CMD_FREE,   0,      4096,   0);
      add_request(CMD_FREE,   65535,  65535,  0);
      add_request(CMD_FREE,   0,      17,     0);
      add_request(CMD_FREE,   0,      0,      0);
      add_request(CMD_ALLOC,  4080,   0,      0);
      add_request(CMD_UNUSED, 65535,  65535,  0);
      add_request(CMD_ALLOC,  8,      0,      0);
      add_request(CMD_FREE,   0,      16,     0);
      add_request(CMD_REINIT, 0,      0,      0);
      add_request(CMD_ALLOC,  4073,   0,      0);
      add_request(CMD_REINIT, 65535,  65535,  0);
      add_request(CMD_ALLOC,  4064,   0,      0);
      add_request(CMD_ALLOC,  1,      0,      0);
      add_request(CMD_FREE,   0,      16,     0);
      add_request(CMD_ALLOC,  7,      0,      0);
      add_request(CMD_REINIT, 0,      0,      0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // random phases, generated a few at a time so frees can aim at live blocks
      for (int ph = 0; ph < 4; ph++) begin
         for (int n = 0; n < 108; n++) begin
            while (pending_requests.size() > 4) @(posedge clock);
            add_random_request(phase_idle[ph], ph == 2 && n == 0);
         end
      end

      do @(posedge clock);
      while (pending_requests.size() != 0 || start || awaited_responses.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ffa_pkg.sv
rtl/core/ffa_ram.sv
rtl/core/first_fit_arena_allocator.sv
verif/first_fit_arena_allocator_test.sv
